// ----- design/grid_vertex_dedup_table_macros.svh -----
// ------------------------------------------------------------------
// grid vertex dedup table assertion macros
// shared property wrappers, clocked on clk, disabled in reset
// ------------------------------------------------------------------
`ifndef GRID_VERTEX_DEDUP_TABLE_MACROS_SVH
`define GRID_VERTEX_DEDUP_TABLE_MACROS_SVH

// same-cycle implication
`define GVD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gvd assertion failed");

// next-cycle implication
`define GVD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gvd assertion failed");

`endif

// ----- design/gvd_pkg.sv -----
// ------------------------------------------------------------------
// gvd_pkg
// types and constants of the grid vertex dedup table
// ------------------------------------------------------------------
`default_nettype none

package gvd_pkg;

	localparam int CAPACITY  = 256;
	localparam int FRAC_BITS = 8;

	localparam int COORD_W = 40;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int VI_W    = 8;
	localparam int EC_W    = 9;

	// rounding bias, half away from zero
	localparam int HALF     = (1 << FRAC_BITS) >> 1;
	localparam int HALF_NEG = (HALF == 0) ? 0 : HALF - 1;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_ADDED = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_RES  = 3'b100
	} state_t;

	typedef struct packed {
		logic                      restart;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic [VI_W-1:0] vert_idx;
		status_t         status;
		logic [EC_W-1:0] entry_count;
	} result_t;

	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] z;
	} vert_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		vert_t            key;
	} wr_t;

endpackage

`default_nettype wire

// ----- design/gvd_round.sv -----
// ------------------------------------------------------------------
// gvd_round
// rounds one fixed-point coordinate to an integer, checks 32-bit fit
// ------------------------------------------------------------------
`default_nettype none

module gvd_round (
	input  logic signed [gvd_pkg::COORD_W-1:0] coord,
	output logic        [gvd_pkg::VAL_W-1:0]   value,
	output logic                               fits
);
	import gvd_pkg::*;

	localparam int SUM_W = COORD_W + 1;

	logic signed [SUM_W-1:0] bias;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] shr;

	// negative values take half minus one so the floor shift rounds away from zero
	always_comb begin
		bias = coord[COORD_W-1] ? SUM_W'(HALF_NEG) : SUM_W'(HALF);
		sum  = $signed({coord[COORD_W-1], coord}) + bias;
		shr  = sum >>> FRAC_BITS;
	end

	assign value = shr[VAL_W-1:0];
	assign fits  = (shr[SUM_W-1:VAL_W-1] == '0) || (shr[SUM_W-1:VAL_W-1] == '1);

endmodule

`default_nettype wire

// ----- design/gvd_cell.sv -----
// ------------------------------------------------------------------
// gvd_cell
// one table slot: holds a vertex, compares it against the search key
// ------------------------------------------------------------------
`default_nettype none

module gvd_cell (
	input  logic                        clk,
	input  logic [gvd_pkg::IDX_W-1:0]   cell_idx,
	input  logic [gvd_pkg::CNT_W-1:0]   live_cnt,
	input  gvd_pkg::vert_t              key,
	input  gvd_pkg::wr_t                wr,
	output logic                        hit_s1
);
	import gvd_pkg::*;

	vert_t vert_q;
	logic  live;
	logic  hit_c;

	// only slots below the fill count take part in a search
	assign live  = CNT_W'(cell_idx) < live_cnt;
	assign hit_c = live && (vert_q == key);

	always_ff @(posedge clk) begin
		if (wr.en && (wr.addr == cell_idx)) begin
			vert_q <= wr.key;
		end
		hit_s1 <= hit_c;
	end

endmodule

`default_nettype wire

// ----- design/grid_vertex_dedup_table.sv -----
// ------------------------------------------------------------------
// grid_vertex_dedup_table
// find-or-insert table of unique integer grid vertices
// ------------------------------------------------------------------
// usage:
//   point channel (point_valid/point_ready/point) takes one item per point:
//   restart flag plus three signed fixed-point coordinates
//   result channel (result_valid/result_ready/result) gives exactly one item
//   per point: vertex index, status and the fill count after the point
// sequence:
//   accept edge, then the compare state: rounding and parallel compare in all
//   cells; then the resolve state: resolve the hit and write a new slot; the
//   result is registered when the resolve state fires
//   points are taken one at a time, through the compare-then-resolve pass
//   over the row of cells; the next point is taken in the cycle the
//   current result is loaded
// reset:
//   arst_n clears the fill count and the handshake state; slot contents are
//   not cleared, a slot is read only after it is written
// stall:
//   while result_ready is low a finished result holds in the output register
//   and the following point is held in the resolve cycle until it drains
// ------------------------------------------------------------------
`default_nettype none

module grid_vertex_dedup_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	output logic             point_ready,
	input  gvd_pkg::point_t  point,
	output logic             result_valid,
	input  logic             result_ready,
	output gvd_pkg::result_t result
);
	import gvd_pkg::*;

	`include "grid_vertex_dedup_table_macros.svh"

	state_t            state_q;
	point_t            pt_q;
	vert_t             key_c;
	vert_t             key_s1;
	logic [2:0]        fits_c;
	logic              ok_s1;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  live_cnt;
	logic [CAPACITY-1:0] hit_vec;
	logic [IDX_W-1:0]  hit_idx;
	logic              hit_any;
	logic              room;
	logic              ins;
	logic              out_free;
	logic              fire_res;
	logic              accept;
	wr_t               wr;
	result_t           res_c;
	result_t           result_q;
	logic              result_valid_q;

	// rounding of the held point, one unit per axis
	gvd_round u_round_x (.coord(pt_q.coord_x), .value(key_c.x), .fits(fits_c[0]));
	gvd_round u_round_y (.coord(pt_q.coord_y), .value(key_c.y), .fits(fits_c[1]));
	gvd_round u_round_z (.coord(pt_q.coord_z), .value(key_c.z), .fits(fits_c[2]));

	// restart empties the table before the search
	assign live_cnt = pt_q.restart ? '0 : count_q;

	// row of cells, all compared in the same cycle
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		gvd_cell u_cell (
			.clk      (clk),
			.cell_idx (IDX_W'(g)),
			.live_cnt (live_cnt),
			.key      (key_c),
			.wr       (wr),
			.hit_s1   (hit_vec[g])
		);
	end

	// stored vertices are unique, so at most one cell hits and an or-merge gives its index
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign hit_any  = |hit_vec;
	assign room     = count_q < CNT_W'(CAPACITY);
	assign ins      = ok_s1 && !hit_any && room;
	assign out_free = !result_valid_q || result_ready;
	assign fire_res = (state_q == S_RES) && out_free;
	assign point_ready = (state_q == S_IDLE) || fire_res;
	assign accept   = point_valid && point_ready;

	// slot write on a miss with room left
	assign wr.en   = fire_res && ins;
	assign wr.addr = count_q[IDX_W-1:0];
	assign wr.key  = key_s1;

	// result of the resolve cycle
	always_comb begin
		res_c.vert_idx    = '0;
		res_c.status      = ST_FULL;
		res_c.entry_count = EC_W'(count_q);
		if (!ok_s1) begin
			res_c.status = ST_RANGE;
		end else if (hit_any) begin
			res_c.status   = ST_FOUND;
			res_c.vert_idx = VI_W'(hit_idx);
		end else if (room) begin
			res_c.status      = ST_ADDED;
			res_c.vert_idx    = VI_W'(count_q);
			res_c.entry_count = EC_W'(count_q + CNT_W'(1));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (fire_res) begin
						state_q <= accept ? S_CMP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// fill count: cleared by restart in the compare cycle, bumped on insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_CMP) begin
			count_q <= live_cnt;
		end else if (wr.en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q <= point;
		end
		if (state_q == S_CMP) begin
			key_s1 <= key_c;
			ok_s1  <= &fits_c;
		end
		if (fire_res) begin
			result_q <= res_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_res) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`GVD_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY))
	`GVD_ASSERT_IMP(a_single_hit, state_q == S_RES, $onehot0(hit_vec))
	`GVD_ASSERT_NEXT(a_accept_cmp, accept, state_q == S_CMP)
	`GVD_ASSERT_NEXT(a_insert_inc, wr.en, count_q == $past(count_q) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- verif/vertex_table_checker.sv -----
// ------------------------------------------------------------------
// vertex_table_checker
// watches both channels of the vertex dedup table, keeps its own copy
// of the vertex table, predicts one result per point and compares
// ------------------------------------------------------------------
module vertex_table_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	input  logic             point_ready,
	input  gvd_pkg::point_t  point,
	input  logic             result_valid,
	input  logic             result_ready,
	input  gvd_pkg::result_t result,
	output int               fail_count,
	output int               outstanding
);
	import gvd_pkg::*;

	localparam logic [COORD_W:0] ROUND_BIAS = (COORD_W+1)'((64'd1 << FRAC_BITS) >> 1);
	localparam logic [COORD_W:0] POS_LIMIT  = (COORD_W+1)'((64'd1 << (VAL_W - 1)) - 64'd1);
	localparam logic [COORD_W:0] NEG_LIMIT  = (COORD_W+1)'(64'd1 << (VAL_W - 1));

	vert_t       vertices [CAPACITY];
	int unsigned vertex_total;
	result_t     expected_results [$];

	// nearest integer, halves away from zero; 0 when it leaves signed 32 bits
	function automatic bit snap_to_grid(input logic [COORD_W-1:0] c,
		output logic [VAL_W-1:0] v);
		logic [COORD_W:0] mag;
		logic [COORD_W:0] rmag;
		mag  = c[COORD_W-1] ? {1'b0, ~c + 1'b1} : {1'b0, c};
		rmag = (mag + ROUND_BIAS) >> FRAC_BITS;
		v    = rmag[VAL_W-1:0];
		if (c[COORD_W-1]) begin
			v = ~v + 1'b1;
		end
		return c[COORD_W-1] ? (rmag <= NEG_LIMIT) : (rmag <= POS_LIMIT);
	endfunction

	function automatic result_t find_or_insert(input point_t p);
		logic [VAL_W-1:0] kx, ky, kz;
		vert_t            key;
		result_t          r;
		bit               ok, hit;
		ok  = snap_to_grid(p.coord_x, kx);
		ok  = snap_to_grid(p.coord_y, ky) && ok;
		ok  = snap_to_grid(p.coord_z, kz) && ok;
		key = '{x: kx, y: ky, z: kz};
		// restart empties the table even for a rejected point
		if (p.restart) begin
			vertex_total = 0;
		end
		r.vert_idx = '0;
		r.status   = ST_RANGE;
		if (ok) begin
			hit      = 1'b0;
			r.status = ST_FULL;
			// only filled slots are looked at
			for (int i = 0; i < vertex_total && !hit; i++) begin
				if (vertices[i] == key) begin
					hit        = 1'b1;
					r.vert_idx = i[VI_W-1:0];
					r.status   = ST_FOUND;
				end
			end
			if (!hit && vertex_total < CAPACITY) begin
				vertices[vertex_total] = key;
				r.vert_idx             = vertex_total[VI_W-1:0];
				vertex_total++;
				r.status               = ST_ADDED;
			end
		end
		r.entry_count = vertex_total[EC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_total = 0;
			expected_results.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected item: index %0d status %0d count %0d",
						$time, result.vert_idx, result.status, result.entry_count);
					fail_count++;
				end else begin
					if (result.vert_idx !== expected_results[0].vert_idx ||
						result.status !== expected_results[0].status ||
						result.entry_count !== expected_results[0].entry_count) begin
						$display("%0t: mismatch: expected idx %0d st %0d cnt %0d",
							$time, expected_results[0].vert_idx,
							expected_results[0].status, expected_results[0].entry_count);
						$display("%0t: mismatch: actual   idx %0d st %0d cnt %0d",
							$time, result.vert_idx, result.status, result.entry_count);
						fail_count++;
					end
					void'(expected_results.pop_front());
				end
			end
			if (point_valid && point_ready) begin
				expected_results.push_back(find_or_insert(point));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ------------------------------------------------------------------
// tb
// stimulus and verdict for the grid vertex dedup table: a directed
// pass over rounding edges, range limits and restart, then clustered
// and table-filling random points under bursty input and stalled output
// ------------------------------------------------------------------
module tb;
	import gvd_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int POOL         = 6;
	localparam int RUN_LIMIT    = 2000000;

	// coordinate landmarks around the signed 32-bit limit after rounding
	localparam logic [COORD_W-1:0] MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] MIN_NEG = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] TOP_OK  = MAX_POS - HALF;
	localparam logic [COORD_W-1:0] TOP_BAD = MAX_POS - HALF + 1;
	localparam logic [COORD_W-1:0] ALT_A   = {(COORD_W/2){2'b01}};
	localparam logic [COORD_W-1:0] ALT_B   = {(COORD_W/2){2'b10}};

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_STARVED
	} stall_mode_t;

	logic    clk;
	logic    arst_n;
	logic    point_valid;
	logic    point_ready;
	point_t  point;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	int      fail_count;
	int      outstanding;

	int burst_left;
	int random_items;

	grid_vertex_dedup_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	vertex_table_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// grid value v plus a fraction given in lsbs
	function automatic logic [COORD_W-1:0] fixed_from(input int v, input int frac);
		longint c;
		c = (longint'(v) <<< FRAC_BITS) + longint'(frac);
		return c[COORD_W-1:0];
	endfunction

	// fraction that still rounds back to the same grid value
	function automatic int jitter();
		return int'($urandom_range(0, 2 * HALF - 2)) - (HALF - 1);
	endfunction

	// tiny values half of the time so that neighbors and half-way cases collide
	function automatic int grid_value();
		if ($urandom_range(0, 1) == 0) begin
			return int'($urandom_range(0, 6)) - 3;
		end
		return int'($urandom) >>> 2;
	endfunction

	function automatic logic [COORD_W-1:0] near_grid(input int v);
		logic [63:0] w;
		int          pick;
		pick = $urandom_range(0, 15);
		w    = {$urandom, $urandom};
		case (pick)
			0: return fixed_from(v, HALF);
			1: return fixed_from(v, -HALF);
			2: return w[COORD_W-1:0];
			// straddle the top of the signed 32-bit range
			3: return MAX_POS - COORD_W'($urandom_range(0, 2 * HALF));
			default: return fixed_from(v, jitter());
		endcase
	endfunction

	function automatic point_t make_point(input logic rs, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		point_t p;
		p.restart = rs;
		p.coord_x = x;
		p.coord_y = y;
		p.coord_z = z;
		return p;
	endfunction

	// sender works in bursts; valid drops only across a real gap
	task automatic send_point(input point_t p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				point_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		point       <= p;
		point_valid <= 1'b1;
		@(posedge clk);
		while (!point_ready) @(posedge clk);
	endtask

	// a handful of grid points revisited with jitter, half steps and noise
	task automatic run_cluster(input int length);
		int     px [POOL];
		int     py [POOL];
		int     pz [POOL];
		int     j;
		point_t p;
		for (j = 0; j < POOL; j++) begin
			px[j] = grid_value();
			py[j] = grid_value();
			pz[j] = grid_value();
		end
		for (int k = 0; k < length; k++) begin
			j = $urandom_range(0, POOL - 1);
			p.restart = (k == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 24) == 0);
			p.coord_x = near_grid(px[j]);
			p.coord_y = near_grid(py[j]);
			p.coord_z = near_grid(pz[j]);
			send_point(p);
			random_items++;
		end
	endtask

	// restart, then unique points past capacity with repeats mixed in
	task automatic run_fill();
		int     kx [$];
		int     ky [$];
		int     kz [$];
		int     fresh;
		int     base;
		int     vy, vz;
		int     j;
		bit     first;
		point_t p;
		base  = grid_value();
		fresh = 0;
		first = 1'b1;
		while (fresh < CAPACITY + 8) begin
			p.restart = first;
			first     = 1'b0;
			if (kx.size() != 0 && $urandom_range(0, 7) == 0) begin
				j = $urandom_range(0, kx.size() - 1);
				p.coord_x = fixed_from(kx[j], jitter());
				p.coord_y = fixed_from(ky[j], jitter());
				p.coord_z = fixed_from(kz[j], jitter());
			end else begin
				vy = grid_value();
				vz = grid_value();
				// distinct x per new point keeps every triple unique
				p.coord_x = fixed_from(base + fresh, jitter());
				p.coord_y = fixed_from(vy, jitter());
				p.coord_z = fixed_from(vz, jitter());
				if (fresh < CAPACITY) begin
					kx.push_back(base + fresh);
					ky.push_back(vy);
					kz.push_back(vz);
				end
				fresh++;
			end
			send_point(p);
			random_items++;
		end
	endtask

	// receiver stalls in spans of one pattern each
	initial begin : result_sink
		stall_mode_t mode;
		int          span;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 40);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					READY_ALWAYS:  result_ready <= 1'b1;
					READY_COIN:    result_ready <= ($urandom_range(0, 1) == 1);
					READY_MOSTLY:  result_ready <= ($urandom_range(0, 4) != 0);
					READY_STARVED: result_ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int fill_at;
		bit filled;
		point_valid  <= 1'b0;
		point        <= '0;
		arst_n       <= 1'b0;
		burst_left   = 0;
		random_items = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rounding edges, range limits, restart cases
		send_point(make_point(1'b1, '0, '0, '0));
		send_point(make_point(1'b0, fixed_from(0, HALF - 1), fixed_from(0, 1 - HALF), '0));
		send_point(make_point(1'b0, fixed_from(0, HALF), '0, '0));
		send_point(make_point(1'b0, fixed_from(0, -HALF), '0, '0));
		send_point(make_point(1'b0, fixed_from(1, -HALF), '0, '0));
		send_point(make_point(1'b0, fixed_from(-1, HALF), '0, '0));
		send_point(make_point(1'b0, TOP_OK, TOP_OK, TOP_OK));
		send_point(make_point(1'b0, TOP_BAD, '0, '0));
		send_point(make_point(1'b0, '0, TOP_BAD, '0));
		send_point(make_point(1'b0, '0, '0, TOP_BAD));
		send_point(make_point(1'b0, MAX_POS, MAX_POS, MAX_POS));
		send_point(make_point(1'b0, MIN_NEG, MIN_NEG, MIN_NEG));
		send_point(make_point(1'b0, '1, '1, '1));
		send_point(make_point(1'b0, ALT_A, ALT_B, ALT_A));
		send_point(make_point(1'b0, ALT_B, ALT_A, ALT_B));
		// restart with a rejected point still empties the table
		send_point(make_point(1'b1, TOP_BAD, '0, '0));
		send_point(make_point(1'b0, '0, '0, '0));
		send_point(make_point(1'b1, '0, '0, '0));
		send_point(make_point(1'b0, MIN_NEG, TOP_OK, '0));

		// random: clusters around a few grid points, one run to a full table
		fill_at = $urandom_range(0, 120);
		filled  = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			if (!filled && random_items >= fill_at) begin
				run_fill();
				filled = 1'b1;
			end else begin
				run_cluster($urandom_range(8, 40));
			end
		end
		point_valid <= 1'b0;

		// drain, then watch a little longer for stray result items
		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/gvd_pkg.sv
design/gvd_round.sv
design/gvd_cell.sv
design/grid_vertex_dedup_table.sv
verif/vertex_table_checker.sv
verif/tb.sv
